### rtl/core/ega_pkg.sv
// ----------------------------------------------------------------------------
// ega_pkg: shared types and constants for the extended gcd / inverse block
// Request and result beat layouts, quotient unit command set, status codes.
// ----------------------------------------------------------------------------
package ega_pkg;

  // operand and coefficient widths
  localparam int unsigned OpW   = 31;
  localparam int unsigned CoefW = 32;
  // shift count of the quotient unit: up to OpW-1 left shifts
  localparam int unsigned CntW  = $clog2(OpW);

  // status codes
  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StNoInv  = 2'd1;
  localparam logic [1:0] StZeroMd = 2'd2;

  // request beat
  typedef struct packed {
    logic           kind;
    logic [OpW-1:0] operand_a;
    logic [OpW-1:0] operand_b;
  } req_t;

  // result beat
  typedef struct packed {
    logic [OpW-1:0]          gcd;
    logic signed [CoefW-1:0] coef_a;
    logic signed [CoefW-1:0] coef_b;
    logic [OpW-1:0]          inverse;
    logic [1:0]              status;
  } res_t;

  // quotient unit commands
  typedef enum logic [2:0] {
    QHold,
    QLoad,
    QSwap,
    QAlign,
    QSub
  } qcmd_e;

  // sequencer to quotient unit
  typedef struct packed {
    qcmd_e          cmd;
    logic [OpW-1:0] ld_dividend;
    logic [OpW-1:0] ld_divisor;
  } qctl_t;

  // quotient unit to sequencer
  typedef struct packed {
    logic can_shift;
    logic cnt_zero;
    logic rem_zero;
  } qstat_t;

endpackage

### rtl/core/ega_quot_unit.sv
// ----------------------------------------------------------------------------
// ega_quot_unit: shared shift-subtract quotient unit
// Aligns the divisor under the dividend, then retires one quotient bit per
// cycle, building q*s1 and q*t1 by Horner accumulation alongside.
// ----------------------------------------------------------------------------
module ega_quot_unit (
  input  logic                          clk_i,
  input  ega_pkg::qctl_t                ctl_i,
  input  logic [ega_pkg::CoefW-1:0]     s_mul_i,
  input  logic [ega_pkg::CoefW-1:0]     t_mul_i,
  output ega_pkg::qstat_t               stat_o,
  output logic [ega_pkg::OpW-1:0]       div_o,
  output logic [ega_pkg::CoefW-1:0]     s_prod_o,
  output logic [ega_pkg::CoefW-1:0]     t_prod_o
);

  logic [ega_pkg::OpW-1:0]   rem_q, rem_d;
  logic [ega_pkg::OpW-1:0]   div_q, div_d;
  logic [ega_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [ega_pkg::CoefW-1:0] sp_q, sp_d;
  logic [ega_pkg::CoefW-1:0] tp_q, tp_d;
  logic                      ge;

  // remainder covers the shifted divisor
  assign ge = (rem_q >= div_q);

  // flags for the sequencer
  assign stat_o.can_shift = ({div_q, 1'b0} <= {1'b0, rem_q});
  assign stat_o.cnt_zero  = (cnt_q == '0);
  assign stat_o.rem_zero  = (rem_q == '0);

  // datapath next state
  always_comb begin
    rem_d = rem_q;
    div_d = div_q;
    cnt_d = cnt_q;
    sp_d  = sp_q;
    tp_d  = tp_q;
    case (ctl_i.cmd)
      ega_pkg::QLoad: begin
        rem_d = ctl_i.ld_dividend;
        div_d = ctl_i.ld_divisor;
        cnt_d = '0;
        sp_d  = '0;
        tp_d  = '0;
      end
      ega_pkg::QSwap: begin
        rem_d = div_q;
        div_d = rem_q;
        cnt_d = '0;
        sp_d  = '0;
        tp_d  = '0;
      end
      ega_pkg::QAlign: begin
        div_d = {div_q[ega_pkg::OpW-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
      end
      ega_pkg::QSub: begin
        if (ge) begin
          rem_d = rem_q - div_q;
        end
        sp_d = {sp_q[ega_pkg::CoefW-2:0], 1'b0} + (ge ? s_mul_i : '0);
        tp_d = {tp_q[ega_pkg::CoefW-2:0], 1'b0} + (ge ? t_mul_i : '0);
        if (cnt_q != '0) begin
          div_d = {1'b0, div_q[ega_pkg::OpW-1:1]};
          cnt_d = cnt_q - 1'b1;
        end
      end
      default: begin
        rem_d = rem_q;
      end
    endcase
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    cnt_q <= cnt_d;
    sp_q  <= sp_d;
    tp_q  <= tp_d;
  end

  assign div_o    = div_q;
  assign s_prod_o = sp_q;
  assign t_prod_o = tp_q;

endmodule

### rtl/core/extended_gcd_mod_inverse.sv
// ----------------------------------------------------------------------------
// extended_gcd_mod_inverse: extended Euclid with modular inverse
// Sequencer, Bezout coefficient registers and result stage around a shared
// shift-subtract quotient unit.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_i and raise start_i; the beat is taken at a
//   rising edge with start_i high and busy_o low. busy_o stays high until the
//   work is finished.
//   Result channel: done_o pulses for one cycle with the result beat on res_o.
//   The receiver cannot stall; the beat must be taken in that cycle.
// Sequence:
//   Each Euclid step runs in the quotient unit as align shifts, one subtract
//   per quotient bit and one update. SFix then reduces the inverse, SDone
//   forms the result, and done_o is raised on the following cycle. A zero
//   operand_b skips the loop. One request is handled at a time.
//   busy_o drops while done_o is shown, so the next request may start then.
// Reset:
//   rst_ni clears the sequencer and the strobe; no result is pending after.
// ----------------------------------------------------------------------------
module extended_gcd_mod_inverse (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  ega_pkg::req_t req_i,
  output logic          done_o,
  output ega_pkg::res_t res_o
);

  // sequencer states
  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SAlign  = 3'd1;
  localparam logic [2:0] SSub    = 3'd2;
  localparam logic [2:0] SUpdate = 3'd3;
  localparam logic [2:0] SFix    = 3'd4;
  localparam logic [2:0] SDone   = 3'd5;

  logic [2:0]                state_q, state_d;
  logic                      done_q, done_d;
  ega_pkg::res_t             res_q, res_d;

  logic                      kind_q, kind_d;
  logic [ega_pkg::OpW-1:0]   mod_q, mod_d;
  logic [ega_pkg::OpW-1:0]   gcd_q, gcd_d;
  logic [ega_pkg::CoefW-1:0] s0_q, s0_d, s1_q, s1_d;
  logic [ega_pkg::CoefW-1:0] t0_q, t0_d, t1_q, t1_d;
  logic [ega_pkg::OpW-1:0]   mr_q, mr_d;
  logic                      neg_q, neg_d;

  ega_pkg::qctl_t            qctl;
  ega_pkg::qstat_t           qstat;
  logic [ega_pkg::OpW-1:0]   q_div;
  logic [ega_pkg::CoefW-1:0] q_sp, q_tp;

  logic [ega_pkg::CoefW-1:0] mag;
  logic [ega_pkg::CoefW-1:0] mag_red;
  logic [ega_pkg::OpW-1:0]   inv_val;
  logic [1:0]                st_val;

  ega_quot_unit u_quot (
    .clk_i    (clk_i),
    .ctl_i    (qctl),
    .s_mul_i  (s1_q),
    .t_mul_i  (t1_q),
    .stat_o   (qstat),
    .div_o    (q_div),
    .s_prod_o (q_sp),
    .t_prod_o (q_tp)
  );

  // magnitude of s0 reduced once against the modulus
  assign mag     = s0_q[ega_pkg::CoefW-1] ? (~s0_q + 1'b1) : s0_q;
  assign mag_red = (mag >= {1'b0, mod_q}) ? (mag - {1'b0, mod_q}) : mag;

  // fold negative coefficient into [0, modulus)
  assign inv_val = (neg_q && (mr_q != '0)) ? (mod_q - mr_q) : mr_q;

  // status of the finished request
  always_comb begin
    if (!kind_q) begin
      st_val = ega_pkg::StOk;
    end else if (mod_q == '0) begin
      st_val = ega_pkg::StZeroMd;
    end else if (gcd_q > {{(ega_pkg::OpW-1){1'b0}}, 1'b1}) begin
      st_val = ega_pkg::StNoInv;
    end else begin
      st_val = ega_pkg::StOk;
    end
  end

  // sequencer
  always_comb begin
    state_d          = state_q;
    done_d           = 1'b0;
    res_d            = res_q;
    kind_d           = kind_q;
    mod_d            = mod_q;
    gcd_d            = gcd_q;
    s0_d             = s0_q;
    s1_d             = s1_q;
    t0_d             = t0_q;
    t1_d             = t1_q;
    mr_d             = mr_q;
    neg_d            = neg_q;
    qctl.cmd         = ega_pkg::QHold;
    qctl.ld_dividend = req_i.operand_a;
    qctl.ld_divisor  = req_i.operand_b;
    case (state_q)
      SIdle: begin
        if (start_i) begin
          qctl.cmd = ega_pkg::QLoad;
          kind_d   = req_i.kind;
          mod_d    = req_i.operand_b;
          gcd_d    = req_i.operand_a;
          s0_d     = {{(ega_pkg::CoefW-1){1'b0}}, 1'b1};
          s1_d     = '0;
          t0_d     = '0;
          t1_d     = {{(ega_pkg::CoefW-1){1'b0}}, 1'b1};
          state_d  = (req_i.operand_b == '0) ? SFix : SAlign;
        end
      end
      SAlign: begin
        // shift the divisor up, or retire the top quotient bit at once
        if (qstat.can_shift) begin
          qctl.cmd = ega_pkg::QAlign;
        end else begin
          qctl.cmd = ega_pkg::QSub;
          state_d  = qstat.cnt_zero ? SUpdate : SSub;
        end
      end
      SSub: begin
        qctl.cmd = ega_pkg::QSub;
        if (qstat.cnt_zero) begin
          state_d = SUpdate;
        end
      end
      SUpdate: begin
        // advance the coefficient pairs
        s0_d = s1_q;
        s1_d = s0_q - q_sp;
        t0_d = t1_q;
        t1_d = t0_q - q_tp;
        if (qstat.rem_zero) begin
          gcd_d   = q_div;
          state_d = SFix;
        end else begin
          qctl.cmd = ega_pkg::QSwap;
          state_d  = SAlign;
        end
      end
      SFix: begin
        mr_d    = mag_red[ega_pkg::OpW-1:0];
        neg_d   = s0_q[ega_pkg::CoefW-1];
        state_d = SDone;
      end
      SDone: begin
        res_d.gcd     = gcd_q;
        res_d.coef_a  = s0_q;
        res_d.coef_b  = t0_q;
        res_d.status  = st_val;
        res_d.inverse = (kind_q && (st_val == ega_pkg::StOk)) ? inv_val : '0;
        done_d        = 1'b1;
        state_d       = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    kind_q <= kind_d;
    mod_q  <= mod_d;
    gcd_q  <= gcd_d;
    s0_q   <= s0_d;
    s1_q   <= s1_d;
    t0_q   <= t0_d;
    t1_q   <= t1_d;
    mr_q   <= mr_d;
    neg_q  <= neg_d;
  end

  assign busy_o = (state_q != SIdle);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### rtl/core/ega_checker.sv
// ----------------------------------------------------------------------------
// ega_checker: port-level checks for the extended gcd / inverse block
// Watches the request and result beats over time; attached by bind.
// ----------------------------------------------------------------------------
module ega_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input logic          busy_o,
  input logic          done_o,
  input ega_pkg::res_t res_o
);

  // a result beat is shown only once the block is free again
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result beat while busy");

  // an accepted request keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o))
    else $error("accepted request did not hold busy");

  // one beat per request: the strobe is never held high
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held");

  // no inverse is reported with a failing status
  a_inv_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (res_o.status != ega_pkg::StOk)) |-> (res_o.inverse == '0))
    else $error("inverse reported with failing status");

  // status stays a known code
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.status == ega_pkg::StOk || res_o.status == ega_pkg::StNoInv ||
                res_o.status == ega_pkg::StZeroMd))
    else $error("unknown status code");

endmodule

bind extended_gcd_mod_inverse ega_checker u_ega_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .res_o   (res_o)
);
